>>> rtl/i2c_single_byte_master_defines.svh
// assertion macros for the single-byte i2c master
`ifndef I2C_SINGLE_BYTE_MASTER_DEFINES_SVH
`define I2C_SINGLE_BYTE_MASTER_DEFINES_SVH

`ifndef SYNTH
`define I2CSBM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("i2csbm check failed");
`define I2CSBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("i2csbm check failed");
`else
`define I2CSBM_ASSERT(lbl, clk, rst_n, prop)
`define I2CSBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/i2csbm_pkg.sv
package i2csbm_pkg;

	localparam int unsigned ADDR_W = 3;

	localparam logic CFG_IDX_DELAY = 1'b0;

	localparam logic [15:0] DELAY_RESET = 16'd137;
	localparam logic [3:0] REC_LAST = 4'd10;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BUS_BUSY = 2'd1;
	localparam logic [1:0] ST_START_ERR = 2'd2;
	localparam logic [1:0] ST_NO_ACK = 2'd3;

	localparam logic [1:0] MODE_WRITE_DATA = 2'd0;

	localparam logic [1:0] BYTE_REG = 2'd1;
	localparam logic [1:0] BYTE_DATA = 2'd2;

	localparam logic [7:0] DEV_RD_SET = 8'h01;
	localparam logic [7:0] DEV_WR_MASK = 8'hFE;

	typedef struct packed {
		logic       cmd_valid;
		logic [1:0] mode;
		logic [7:0] dev_byte;
		logic [7:0] reg_addr;
		logic [7:0] wdata;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [1:0] status;
		logic [7:0] rdata;
	} res_t;

endpackage

>>> rtl/i2csbm_cfg.sv
module i2csbm_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [i2csbm_pkg::ADDR_W-1:0]     paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	output logic [15:0]                       delay_ticks
);

	logic [15:0] delay_q;
	logic        sel_delay;

	assign sel_delay = (paddr[2] == i2csbm_pkg::CFG_IDX_DELAY);
	assign pready = 1'b1;
	assign delay_ticks = delay_q;
	assign prdata = sel_delay ? {16'd0, delay_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= i2csbm_pkg::DELAY_RESET;
		end else if (psel && penable && pwrite && pready && sel_delay) begin
			delay_q <= pwdata[15:0];
		end
	end

endmodule

>>> rtl/i2csbm_seq.sv
`include "i2c_single_byte_master_defines.svh"

module i2csbm_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  i2csbm_pkg::item_t   item,
	input  logic [15:0]         delay_ticks,
	output i2csbm_pkg::res_t    res
);

	typedef enum logic [4:0] {
		PH_IDLE,
		PH_ST_B,
		PH_ST_C,
		PH_REC,
		PH_TX_OPEN,
		PH_TX_BIT,
		PH_TX_HI,
		PH_TX_LO,
		PH_ACK_OPEN,
		PH_ACK_HI,
		PH_ACK_SMP,
		PH_AFTER_ACK,
		PH_RX_HI,
		PH_RX_SMP,
		PH_NACK_OPEN,
		PH_NACK_HI,
		PH_NACK_LO,
		PH_STOP_LOW,
		PH_STOP_HI,
		PH_STOP_REL,
		PH_STOP_END
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [3:0] bit_q, bit_d;
	logic [7:0] shift_q, shift_d;
	logic [15:0] wait_q, wait_d;
	logic [1:0] mode_q, mode_d;
	logic [7:0] dev_q, dev_d;
	logic [7:0] regad_q, regad_d;
	logic [7:0] data_q, data_d;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	logic [3:0] rec_q, rec_d;
	logic [1:0] code_q, code_d;
	logic [1:0] byte_q, byte_d;
	logic       done;
	logic       rd;

	assign rd = mode_q[1];

	always_comb begin
		phase_d = phase_q;
		bit_d = bit_q;
		shift_d = shift_q;
		wait_d = wait_q;
		mode_d = mode_q;
		dev_d = dev_q;
		regad_d = regad_q;
		data_d = data_q;
		scl_d = scl_q;
		sda_d = sda_q;
		rec_d = rec_q;
		code_d = code_q;
		byte_d = byte_q;
		done = 1'b0;

		if (phase_q == PH_IDLE) begin
			if (item.cmd_valid) begin
				mode_d = item.mode;
				dev_d = item.dev_byte;
				regad_d = item.reg_addr;
				data_d = item.wdata;
				code_d = i2csbm_pkg::ST_OK;
				byte_d = 2'd0;
				bit_d = 4'd0;
				rec_d = 4'd0;
				scl_d = 1'b1;
				sda_d = 1'b1;
				wait_d = delay_ticks;
				phase_d = PH_ST_B;
			end
		end else if (wait_q != 16'd0) begin
			wait_d = wait_q - 16'd1;
		end else begin
			// each step below drives the lines and reloads the wait, but the finishing steps clear the wait and go idle
			wait_d = delay_ticks;
			case (phase_q)
				PH_ST_B: begin
					if (!item.sda_in) begin
						code_d = i2csbm_pkg::ST_BUS_BUSY;
						rec_d = 4'd1;
						scl_d = 1'b0;
						sda_d = 1'b1;
						phase_d = PH_REC;
					end else begin
						scl_d = 1'b1;
						sda_d = 1'b0;
						phase_d = PH_ST_C;
					end
				end
				PH_ST_C: begin
					if (item.sda_in) begin
						code_d = i2csbm_pkg::ST_START_ERR;
						rec_d = 4'd1;
						scl_d = 1'b0;
						sda_d = 1'b1;
						phase_d = PH_REC;
					end else begin
						shift_d = rd ? (dev_q | i2csbm_pkg::DEV_RD_SET)
						             : (dev_q & i2csbm_pkg::DEV_WR_MASK);
						scl_d = 1'b1;
						sda_d = 1'b0;
						phase_d = PH_TX_OPEN;
					end
				end
				PH_REC: begin
					if (rec_q >= i2csbm_pkg::REC_LAST) begin
						done = 1'b1;
						phase_d = PH_IDLE;
						wait_d = 16'd0;
					end else begin
						rec_d = rec_q + 4'd1;
						scl_d = ~rec_d[0];
						sda_d = 1'b1;
						phase_d = PH_REC;
					end
				end
				PH_TX_OPEN: begin
					bit_d = 4'd0;
					scl_d = 1'b0;
					phase_d = PH_TX_BIT;
				end
				PH_TX_BIT: begin
					scl_d = 1'b0;
					sda_d = shift_q[7];
					phase_d = PH_TX_HI;
				end
				PH_TX_HI: begin
					shift_d = {shift_q[6:0], 1'b0};
					scl_d = 1'b1;
					phase_d = PH_TX_LO;
				end
				PH_TX_LO: begin
					bit_d = bit_q + 4'd1;
					scl_d = 1'b0;
					phase_d = bit_d[3] ? PH_ACK_OPEN : PH_TX_BIT;
				end
				PH_ACK_OPEN: begin
					scl_d = 1'b0;
					sda_d = 1'b1;
					phase_d = PH_ACK_HI;
				end
				PH_ACK_HI: begin
					scl_d = 1'b1;
					sda_d = 1'b1;
					phase_d = PH_ACK_SMP;
				end
				PH_ACK_SMP: begin
					if (item.sda_in) begin
						code_d = i2csbm_pkg::ST_NO_ACK;
						scl_d = 1'b0;
						sda_d = 1'b0;
						phase_d = PH_STOP_HI;
					end else begin
						scl_d = 1'b0;
						sda_d = 1'b1;
						phase_d = PH_AFTER_ACK;
					end
				end
				PH_AFTER_ACK: begin
					byte_d = byte_q + 2'd1;
					scl_d = 1'b0;
					if (rd) begin
						shift_d = 8'd0;
						bit_d = 4'd0;
						sda_d = 1'b1;
						phase_d = PH_RX_HI;
					end else if (byte_d == i2csbm_pkg::BYTE_REG) begin
						shift_d = regad_q;
						bit_d = 4'd0;
						phase_d = PH_TX_BIT;
					end else if (byte_d == i2csbm_pkg::BYTE_DATA &&
					             mode_q == i2csbm_pkg::MODE_WRITE_DATA) begin
						shift_d = data_q;
						bit_d = 4'd0;
						phase_d = PH_TX_BIT;
					end else begin
						sda_d = 1'b0;
						phase_d = PH_STOP_HI;
					end
				end
				PH_RX_HI: begin
					scl_d = 1'b1;
					sda_d = 1'b1;
					phase_d = PH_RX_SMP;
				end
				PH_RX_SMP: begin
					shift_d = {shift_q[6:0], item.sda_in};
					bit_d = bit_q + 4'd1;
					scl_d = 1'b0;
					sda_d = 1'b1;
					phase_d = bit_d[3] ? PH_NACK_OPEN : PH_RX_HI;
				end
				PH_NACK_OPEN: begin
					scl_d = 1'b0;
					sda_d = 1'b1;
					phase_d = PH_NACK_HI;
				end
				PH_NACK_HI: begin
					scl_d = 1'b1;
					sda_d = 1'b1;
					phase_d = PH_NACK_LO;
				end
				PH_NACK_LO: begin
					scl_d = 1'b0;
					sda_d = 1'b1;
					phase_d = PH_STOP_LOW;
				end
				PH_STOP_LOW: begin
					scl_d = 1'b0;
					sda_d = 1'b0;
					phase_d = PH_STOP_HI;
				end
				PH_STOP_HI: begin
					scl_d = 1'b1;
					sda_d = 1'b0;
					phase_d = PH_STOP_REL;
				end
				PH_STOP_REL: begin
					scl_d = 1'b1;
					sda_d = 1'b1;
					phase_d = PH_STOP_END;
				end
				default: begin
					done = 1'b1;
					phase_d = PH_IDLE;
					wait_d = 16'd0;
				end
			endcase
		end
	end

	always_comb begin
		res.scl_out = scl_d;
		res.sda_out = sda_d;
		res.busy_res = (phase_d != PH_IDLE);
		res.done_res = done;
		res.status = done ? code_d : i2csbm_pkg::ST_OK;
		res.rdata = (done && code_d == i2csbm_pkg::ST_OK && rd) ? shift_d : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_q <= 4'd0;
			shift_q <= 8'd0;
			wait_q <= 16'd0;
			mode_q <= 2'd0;
			dev_q <= 8'd0;
			regad_q <= 8'd0;
			data_q <= 8'd0;
			scl_q <= 1'b1;
			sda_q <= 1'b1;
			rec_q <= 4'd0;
			code_q <= i2csbm_pkg::ST_OK;
			byte_q <= 2'd0;
		end else if (step_en) begin
			phase_q <= phase_d;
			bit_q <= bit_d;
			shift_q <= shift_d;
			wait_q <= wait_d;
			mode_q <= mode_d;
			dev_q <= dev_d;
			regad_q <= regad_d;
			data_q <= data_d;
			scl_q <= scl_d;
			sda_q <= sda_d;
			rec_q <= rec_d;
			code_q <= code_d;
			byte_q <= byte_d;
		end
	end

	`I2CSBM_ASSERT(a_idle_no_wait, clk, arst_n, phase_q != PH_IDLE || wait_q == 16'd0)
	`I2CSBM_ASSERT(a_rec_bound, clk, arst_n, rec_q <= i2csbm_pkg::REC_LAST)
	`I2CSBM_ASSERT(a_bit_bound, clk, arst_n, bit_q <= 4'd8)
	`I2CSBM_ASSERT_NEXT(a_done_idle, clk, arst_n, step_en && done, phase_q == PH_IDLE)

endmodule

>>> rtl/i2csbm_out.sv
module i2csbm_out (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  i2csbm_pkg::res_t   res_in,
	output logic               out_valid,
	input  logic               out_stall,
	output i2csbm_pkg::res_t   res_out,
	output logic               step_en
);

	logic             valid_q;
	i2csbm_pkg::res_t res_q;

	assign in_stall = valid_q && out_stall;
	assign step_en = in_valid && !in_stall;
	assign out_valid = valid_q;
	assign res_out = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= step_en || (valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_q <= res_in;
		end
	end

endmodule

>>> rtl/i2c_single_byte_master.sv
// a result is held in one output register and appears in the cycle after its request is taken
// throughput: one request per cycle while the output is not stalled, each request being one bus tick
// each taken request steps the sequencer, whose result ends in the result register
// reset: sequencer idle, its scl and sda registers released, delay_ticks back to 137
// no clearing pass after reset, requests are taken at once
module i2c_single_byte_master (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd_valid,
	input  logic [1:0]                    mode,
	input  logic [7:0]                    dev_byte,
	input  logic [7:0]                    reg_addr,
	input  logic [7:0]                    wdata,
	input  logic                          sda_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          scl_out,
	output logic                          sda_out,
	output logic                          busy_res,
	output logic                          done_res,
	output logic [1:0]                    status,
	output logic [7:0]                    rdata,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [i2csbm_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic              step_en;
	logic [15:0]       delay_ticks;
	i2csbm_pkg::item_t item;
	i2csbm_pkg::res_t  res_d;
	i2csbm_pkg::res_t  res_q;

	always_comb begin
		item.cmd_valid = cmd_valid;
		item.mode = mode;
		item.dev_byte = dev_byte;
		item.reg_addr = reg_addr;
		item.wdata = wdata;
		item.sda_in = sda_in;
	end

	i2csbm_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.delay_ticks (delay_ticks)
	);

	i2csbm_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (step_en),
		.item        (item),
		.delay_ticks (delay_ticks),
		.res         (res_d)
	);

	i2csbm_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.res_in    (res_d),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_out   (res_q),
		.step_en   (step_en)
	);

	assign scl_out = res_q.scl_out;
	assign sda_out = res_q.sda_out;
	assign busy_res = res_q.busy_res;
	assign done_res = res_q.done_res;
	assign status = res_q.status;
	assign rdata = res_q.rdata;

endmodule

>>> sim/testbench.sv
module testbench;

	localparam logic IDX_UNUSED = 1'b1;
	localparam logic [i2csbm_pkg::ADDR_W-1:0] ADDR_DELAY = {i2csbm_pkg::CFG_IDX_DELAY, 2'b00};
	localparam logic [i2csbm_pkg::ADDR_W-1:0] ADDR_UNUSED = {IDX_UNUSED, 2'b00};
	localparam logic [1:0] MODE_PTR_SET = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;
	localparam logic [1:0] MODE_READ_ALT = 2'd3;

	typedef enum logic [4:0] {
		STEP_IDLE, STEP_START_CHECK, STEP_START_LOW, STEP_RECOVER,
		STEP_TX_OPEN, STEP_TX_BIT, STEP_TX_HIGH, STEP_TX_LOW,
		STEP_ACK_OPEN, STEP_ACK_HIGH, STEP_ACK_SAMPLE, STEP_AFTER_ACK,
		STEP_RX_HIGH, STEP_RX_SAMPLE, STEP_NACK_OPEN, STEP_NACK_HIGH, STEP_NACK_LOW,
		STEP_STOP_LOW, STEP_STOP_HIGH, STEP_STOP_REL, STEP_STOP_END
	} seq_step_e;

	typedef enum logic [2:0] {
		FAULT_NONE, FAULT_BUS_BUSY, FAULT_START, FAULT_NO_ACK, FAULT_NOISE
	} fault_e;

	typedef struct {
		seq_step_e   step;
		logic [3:0]  bits;
		logic [7:0]  shreg;
		logic [15:0] wcnt;
		logic [1:0]  held_mode;
		logic [7:0]  held_dev;
		logic [7:0]  held_reg;
		logic [7:0]  held_data;
		logic        scl;
		logic        sda;
		logic [3:0]  rec;
		logic [1:0]  code;
		logic [1:0]  nbytes;
	} master_st_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        cmd_valid = 1'b0;
	logic [1:0]  mode = 2'd0;
	logic [7:0]  dev_byte = 8'd0;
	logic [7:0]  reg_addr = 8'd0;
	logic [7:0]  wdata = 8'd0;
	logic        sda_in = 1'b1;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        scl_out;
	logic        sda_out;
	logic        busy_res;
	logic        done_res;
	logic [1:0]  status;
	logic [7:0]  rdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [i2csbm_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	logic [15:0]       delay_now;
	master_st_t        pred_st;
	master_st_t        gen_st;
	i2csbm_pkg::item_t tick_q[$];
	i2csbm_pkg::res_t  want_lines_q[$];
	i2csbm_pkg::item_t next_tick;
	logic        tick_taken = 1'b0;
	logic        failed = 1'b0;
	int          n_planned = 0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;

	i2c_single_byte_master u_dut (.*);

	always #6 clk = ~clk;

	function automatic void reset_state(output master_st_t s);
		s.step = STEP_IDLE;
		s.bits = 4'd0;
		s.shreg = 8'd0;
		s.wcnt = 16'd0;
		s.held_mode = 2'd0;
		s.held_dev = 8'd0;
		s.held_reg = 8'd0;
		s.held_data = 8'd0;
		s.scl = 1'b1;
		s.sda = 1'b1;
		s.rec = 4'd0;
		s.code = i2csbm_pkg::ST_OK;
		s.nbytes = 2'd0;
	endfunction

	function automatic void put_lines(inout master_st_t s, input logic c, input logic d,
		input seq_step_e nx);
		s.scl = c;
		s.sda = d;
		s.wcnt = delay_now;
		s.step = nx;
	endfunction

	function automatic void start_recovery(inout master_st_t s, input logic [1:0] code);
		s.code = code;
		s.rec = 4'd1;
		put_lines(s, 1'b0, 1'b1, STEP_RECOVER);
	endfunction

	function automatic void load_byte(inout master_st_t s, input logic [7:0] b);
		s.shreg = b;
		s.bits = 4'd0;
		put_lines(s, 1'b0, s.sda, STEP_TX_BIT);
	endfunction

	function automatic void step_sequencer(inout master_st_t s, input i2csbm_pkg::item_t it,
		output i2csbm_pkg::res_t r);
		logic fin;
		logic rd;
		fin = 1'b0;
		if (s.step == STEP_IDLE) begin
			if (it.cmd_valid) begin
				s.held_mode = it.mode;
				s.held_dev = it.dev_byte;
				s.held_reg = it.reg_addr;
				s.held_data = it.wdata;
				s.code = i2csbm_pkg::ST_OK;
				s.nbytes = 2'd0;
				s.bits = 4'd0;
				s.rec = 4'd0;
				put_lines(s, 1'b1, 1'b1, STEP_START_CHECK);
			end
		end else if (s.wcnt != 16'd0) begin
			s.wcnt = s.wcnt - 16'd1;
		end else begin
			rd = s.held_mode[1];
			case (s.step)
				STEP_START_CHECK: begin
					if (!it.sda_in) start_recovery(s, i2csbm_pkg::ST_BUS_BUSY);
					else put_lines(s, 1'b1, 1'b0, STEP_START_LOW);
				end
				STEP_START_LOW: begin
					if (it.sda_in) begin
						start_recovery(s, i2csbm_pkg::ST_START_ERR);
					end else begin
						s.shreg = rd ? (s.held_dev | i2csbm_pkg::DEV_RD_SET)
							: (s.held_dev & i2csbm_pkg::DEV_WR_MASK);
						put_lines(s, 1'b1, 1'b0, STEP_TX_OPEN);
					end
				end
				STEP_RECOVER: begin
					if (s.rec >= i2csbm_pkg::REC_LAST) begin
						fin = 1'b1;
						s.step = STEP_IDLE;
						s.wcnt = 16'd0;
					end else begin
						s.rec = s.rec + 4'd1;
						put_lines(s, ~s.rec[0], 1'b1, STEP_RECOVER);
					end
				end
				STEP_TX_OPEN: load_byte(s, s.shreg);
				STEP_TX_BIT: put_lines(s, 1'b0, s.shreg[7], STEP_TX_HIGH);
				STEP_TX_HIGH: begin
					s.shreg = {s.shreg[6:0], 1'b0};
					put_lines(s, 1'b1, s.sda, STEP_TX_LOW);
				end
				STEP_TX_LOW: begin
					s.bits = s.bits + 4'd1;
					put_lines(s, 1'b0, s.sda, s.bits >= 4'd8 ? STEP_ACK_OPEN : STEP_TX_BIT);
				end
				STEP_ACK_OPEN: put_lines(s, 1'b0, 1'b1, STEP_ACK_HIGH);
				STEP_ACK_HIGH: put_lines(s, 1'b1, 1'b1, STEP_ACK_SAMPLE);
				STEP_ACK_SAMPLE: begin
					if (it.sda_in) begin
						s.code = i2csbm_pkg::ST_NO_ACK;
						put_lines(s, 1'b0, 1'b0, STEP_STOP_HIGH);
					end else begin
						put_lines(s, 1'b0, 1'b1, STEP_AFTER_ACK);
					end
				end
				STEP_AFTER_ACK: begin
					s.nbytes = s.nbytes + 2'd1;
					if (rd) begin
						s.shreg = 8'd0;
						s.bits = 4'd0;
						put_lines(s, 1'b0, 1'b1, STEP_RX_HIGH);
					end else if (s.nbytes == i2csbm_pkg::BYTE_REG) begin
						load_byte(s, s.held_reg);
					end else if (s.nbytes == i2csbm_pkg::BYTE_DATA &&
						s.held_mode == i2csbm_pkg::MODE_WRITE_DATA) begin
						load_byte(s, s.held_data);
					end else begin
						put_lines(s, 1'b0, 1'b0, STEP_STOP_HIGH);
					end
				end
				STEP_RX_HIGH: put_lines(s, 1'b1, 1'b1, STEP_RX_SAMPLE);
				STEP_RX_SAMPLE: begin
					s.shreg = {s.shreg[6:0], it.sda_in};
					s.bits = s.bits + 4'd1;
					put_lines(s, 1'b0, 1'b1, s.bits >= 4'd8 ? STEP_NACK_OPEN : STEP_RX_HIGH);
				end
				STEP_NACK_OPEN: put_lines(s, 1'b0, 1'b1, STEP_NACK_HIGH);
				STEP_NACK_HIGH: put_lines(s, 1'b1, 1'b1, STEP_NACK_LOW);
				STEP_NACK_LOW: put_lines(s, 1'b0, 1'b1, STEP_STOP_LOW);
				STEP_STOP_LOW: put_lines(s, 1'b0, 1'b0, STEP_STOP_HIGH);
				STEP_STOP_HIGH: put_lines(s, 1'b1, 1'b0, STEP_STOP_REL);
				STEP_STOP_REL: put_lines(s, 1'b1, 1'b1, STEP_STOP_END);
				default: begin
					fin = 1'b1;
					s.step = STEP_IDLE;
					s.wcnt = 16'd0;
				end
			endcase
		end
		rd = s.held_mode[1];
		r.scl_out = s.scl;
		r.sda_out = s.sda;
		r.busy_res = (s.step != STEP_IDLE);
		r.done_res = fin;
		r.status = fin ? s.code : i2csbm_pkg::ST_OK;
		r.rdata = (fin && s.code == i2csbm_pkg::ST_OK && rd) ? s.shreg : 8'd0;
	endfunction

	function automatic void check_field(input string nm, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			$display("%0t mismatch on %s: expected %0h actual %0h", $time, nm, want, got);
			failed = 1'b1;
		end
	endfunction

	// request side: a new tick only once the previous one was taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || tick_taken) begin
			if (tick_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				next_tick = tick_q.pop_front();
				{cmd_valid, mode, dev_byte, reg_addr, wdata, sda_in} <= next_tick;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= arst_n && ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin : watch_bus
		i2csbm_pkg::res_t want;
		i2csbm_pkg::res_t got;
		if (!arst_n) begin
			tick_taken <= 1'b0;
		end else begin
			tick_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				step_sequencer(pred_st, {cmd_valid, mode, dev_byte, reg_addr, wdata, sda_in},
					want);
				want_lines_q.push_back(want);
			end
			if (out_valid && !out_stall) begin
				got = {scl_out, sda_out, busy_res, done_res, status, rdata};
				if (want_lines_q.size() == 0) begin
					$display("%0t unexpected result: expected none actual %0h", $time, got);
					failed = 1'b1;
				end else begin
					want = want_lines_q.pop_front();
					check_field("scl_out", 8'(want.scl_out), 8'(got.scl_out));
					check_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
					check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
					check_field("done_res", 8'(want.done_res), 8'(got.done_res));
					check_field("status", 8'(want.status), 8'(got.status));
					check_field("rdata", want.rdata, got.rdata);
				end
			end
		end
	end

	task automatic apb_write(input logic [i2csbm_pkg::ADDR_W-1:0] a, input logic [31:0] d);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= a;
		pwdata <= d;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (a == ADDR_DELAY) delay_now = d[15:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_read(input logic [i2csbm_pkg::ADDR_W-1:0] a, input logic [15:0] want);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= a;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== 32'(want)) begin
			$display("%0t register read mismatch: expected %0h actual %0h", $time, want,
				prdata);
			failed = 1'b1;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic plan_tick(input i2csbm_pkg::item_t it);
		i2csbm_pkg::res_t r;
		step_sequencer(gen_st, it, r);
		tick_q.push_back(it);
		n_planned++;
	endtask

	task automatic queue_idle(input int n);
		i2csbm_pkg::item_t it;
		repeat (n) begin
			it.cmd_valid = 1'b0;
			it.mode = 2'($urandom);
			it.dev_byte = 8'($urandom);
			it.reg_addr = 8'($urandom);
			it.wdata = 8'($urandom);
			it.sda_in = 1'($urandom);
			plan_tick(it);
		end
	endtask

	// sda_in follows the bus step the sequencer will be in, so most transfers get deep
	task automatic queue_transfer(input logic [1:0] md, input logic [7:0] dev,
		input logic [7:0] rg, input logic [7:0] dat, input fault_e flt, input int nack_at,
		input logic [7:0] rx_byte, input logic busy_cmds);
		i2csbm_pkg::item_t it;
		it.cmd_valid = 1'b1;
		it.mode = md;
		it.dev_byte = dev;
		it.reg_addr = rg;
		it.wdata = dat;
		it.sda_in = 1'($urandom);
		plan_tick(it);
		while (gen_st.step != STEP_IDLE) begin
			it.cmd_valid = busy_cmds & 1'($urandom);
			it.mode = 2'($urandom);
			it.dev_byte = 8'($urandom);
			it.reg_addr = 8'($urandom);
			it.wdata = 8'($urandom);
			it.sda_in = 1'($urandom);
			if (gen_st.wcnt == 16'd0 && flt != FAULT_NOISE) begin
				case (gen_st.step)
					STEP_START_CHECK: it.sda_in = (flt != FAULT_BUS_BUSY);
					STEP_START_LOW: it.sda_in = (flt == FAULT_START);
					STEP_ACK_SAMPLE:
						it.sda_in = (flt == FAULT_NO_ACK && int'(gen_st.nbytes) == nack_at);
					STEP_RX_SAMPLE: it.sda_in = rx_byte[3'd7 - gen_st.bits[2:0]];
					default: ;
				endcase
			end
			plan_tick(it);
		end
	endtask

	task automatic queue_random_transfers(input int target);
		int first;
		int pick;
		fault_e flt;
		first = n_planned;
		while (n_planned - first < target) begin
			queue_idle($urandom_range(0, 4));
			pick = $urandom_range(0, 99);
			flt = pick < 62 ? FAULT_NONE : pick < 70 ? FAULT_BUS_BUSY :
				pick < 78 ? FAULT_START : pick < 92 ? FAULT_NO_ACK : FAULT_NOISE;
			queue_transfer(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), flt,
				$urandom_range(0, 2), 8'($urandom), 1'($urandom));
		end
	endtask

	task automatic settle();
		while (tick_q.size() != 0 || in_valid || want_lines_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		delay_now = i2csbm_pkg::DELAY_RESET;
		reset_state(pred_st);
		reset_state(gen_st);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset rate, then a short rate with the bus held low so the recovery runs in full
		apb_read(ADDR_DELAY, i2csbm_pkg::DELAY_RESET);
		queue_idle(10);
		settle();
		apb_write(ADDR_DELAY, 32'd2);
		apb_read(ADDR_DELAY, 16'd2);
		queue_transfer(i2csbm_pkg::MODE_WRITE_DATA, 8'h3C, 8'h11, 8'h22, FAULT_BUS_BUSY, 0,
			8'h00, 1'b0);
		settle();

		// zero delay, each kind of transfer and each fault at least once
		apb_write(ADDR_DELAY, 32'd0);
		apb_read(ADDR_DELAY, 16'd0);
		queue_transfer(i2csbm_pkg::MODE_WRITE_DATA, 8'hFF, 8'h00, 8'hFF, FAULT_NONE, 0,
			8'h00, 1'b0);
		queue_transfer(i2csbm_pkg::MODE_WRITE_DATA, 8'h00, 8'hFF, 8'h00, FAULT_NONE, 0,
			8'h00, 1'b1);
		queue_transfer(MODE_PTR_SET, 8'hA5, 8'h5A, 8'hC3, FAULT_NONE, 0, 8'h00, 1'b1);
		queue_transfer(MODE_READ, 8'h00, 8'h12, 8'h34, FAULT_NONE, 0, 8'hFF, 1'b0);
		queue_transfer(MODE_READ, 8'hFE, 8'h56, 8'h78, FAULT_NONE, 0, 8'h00, 1'b1);
		queue_transfer(MODE_READ_ALT, 8'h55, 8'h9A, 8'hBC, FAULT_NONE, 0, 8'hA5, 1'b0);
		queue_transfer(i2csbm_pkg::MODE_WRITE_DATA, 8'h90, 8'h01, 8'h02, FAULT_BUS_BUSY, 0,
			8'h00, 1'b0);
		queue_transfer(MODE_READ, 8'h91, 8'h03, 8'h04, FAULT_START, 0, 8'h00, 1'b1);
		queue_transfer(i2csbm_pkg::MODE_WRITE_DATA, 8'hD0, 8'h05, 8'h06, FAULT_NO_ACK, 0,
			8'h00, 1'b0);
		queue_transfer(i2csbm_pkg::MODE_WRITE_DATA, 8'hD0, 8'h07, 8'h08, FAULT_NO_ACK, 1,
			8'h00, 1'b0);
		queue_transfer(i2csbm_pkg::MODE_WRITE_DATA, 8'hD0, 8'h09, 8'h0A, FAULT_NO_ACK, 2,
			8'h00, 1'b1);
		queue_transfer(MODE_PTR_SET, 8'hD1, 8'h0B, 8'h0C, FAULT_NO_ACK, 1, 8'h00, 1'b0);
		queue_transfer(MODE_READ, 8'hD1, 8'h0D, 8'h0E, FAULT_NO_ACK, 0, 8'h3C, 1'b0);
		queue_transfer(MODE_READ_ALT, 8'h6E, 8'h0F, 8'h10, FAULT_NOISE, 0, 8'h00, 1'b1);
		settle();

		send_idle_pct = 63;
		queue_random_transfers(250);
		settle();

		send_idle_pct = 0;
		stall_pct = 63;
		queue_random_transfers(250);
		settle();

		apb_write(ADDR_DELAY, 32'd1);
		apb_read(ADDR_DELAY, 16'd1);
		send_idle_pct = 21;
		stall_pct = 21;
		queue_random_transfers(200);
		settle();

		apb_write(ADDR_DELAY, 32'd0);
		send_idle_pct = 0;
		stall_pct = 0;
		queue_random_transfers(100);
		settle();
		queue_random_transfers(100);
		settle();

		// widest setting, upper bits of the write dropped, unused index ignored
		apb_write(ADDR_DELAY, 32'hFFFF_FFFF);
		apb_read(ADDR_DELAY, 16'hFFFF);
		apb_write(ADDR_UNUSED, 32'd5);
		apb_read(ADDR_DELAY, 16'hFFFF);
		queue_idle(20);
		settle();

		if (!failed) $display("PASSED: all results match");
		else $display("FAILED: results differ");
		$finish;
	end

	initial begin
		#(12 * 600000);
		$display("FAILED: results differ");
		$finish;
	end
endmodule
